FILE: sv/tgmu_pkg.sv
`timescale 1ns / 1ps

package tgmu_pkg;

	localparam int CRD_W   = 32;
	localparam int LINES_W = 21;
	localparam int STAT_W  = 3;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_ADD    = 2'd1,
		CMD_NEXT   = 2'd2,
		CMD_REWIND = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_COORD     = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_FULL      = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_MUL  = 5'b00010,
		S_CHK  = 5'b00100,
		S_SCAN = 5'b01000,
		S_FIN  = 5'b10000
	} state_t;

endpackage

FILE: sv/track_grid_merge_unique_unit.sv
`timescale 1ns / 1ps
// Path, input transfer to result register: clear, empty add, refused add and exhausted next
// go straight to S_FIN; an add that is range-checked passes S_MUL, S_CHK and S_FIN (multiply,
// check, write); next and rewind walk one memory entry per cycle over the filled entries.
// One item at a time: input is taken again in the cycle after the result register loads;
// a result held by out_stall blocks only the next load.
// Reset empties the table; the pattern and cursor memories are not cleared.
module track_grid_merge_unique_unit
	import tgmu_pkg::*;
#(
	parameter int MAX_PATTERNS = 16,
	parameter int COUNT_BITS   = 20
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               command,
	input  logic signed [CRD_W-1:0]  origin,
	input  logic signed [LINES_W-1:0] lines,
	input  logic signed [CRD_W-1:0]  pitch,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [CRD_W-1:0]  coordinate,
	output logic [STAT_W-1:0]        status
);

	localparam int IW  = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
	localparam int UW  = $clog2(MAX_PATTERNS + 1);
	localparam int CW  = COUNT_BITS;
	localparam int PW  = 2 * CRD_W + CW;
	localparam int CUW = CRD_W + CW;
	localparam int MW  = LINES_W + CRD_W;

	state_t state_q;

	logic [PW-1:0]  pat_mem [MAX_PATTERNS];
	logic [CUW-1:0] cur_mem [MAX_PATTERNS];
	logic [PW-1:0]  pat_rd_q;
	logic [CUW-1:0] cur_rd_q;

	logic [UW-1:0]  used_q;
	logic [UW-1:0]  cnt_q;
	logic           v_s1;
	logic [IW-1:0]  addr_s1;
	logic           rew_q;
	logic signed [CRD_W-1:0] hit_q;
	logic           acc_found_q;
	logic signed [CRD_W-1:0] acc_best_q;
	logic           cache_found_q;
	logic signed [CRD_W-1:0] cache_best_q;

	logic signed [CRD_W-1:0]   origin_q;
	logic signed [LINES_W-1:0] lines_q;
	logic signed [CRD_W-1:0]   pitch_q;
	logic signed [MW-1:0]      prod_s2;

	status_t                 res_status_q;
	logic signed [CRD_W-1:0] res_coord_q;
	logic                    out_valid_q;
	status_t                 status_q;
	logic signed [CRD_W-1:0] coordinate_q;

	logic                    in_take;
	logic [IW-1:0]           rd_addr;

	logic signed [CRD_W-1:0] scan_val;
	logic [CW-1:0]           scan_left;
	logic signed [CRD_W-1:0] pat_start;
	logic [CRD_W-1:0]        pat_pitch;
	logic [CW-1:0]           pat_total;
	logic signed [CRD_W-1:0] nv;
	logic [CW-1:0]           nl;
	logic                    hit;
	logic                    take;

	logic signed [LINES_W-1:0] cm1;
	logic signed [MW:0]        last;
	logic                      in_rng;
	logic [CRD_W-1:0]          cnt32;
	logic                      cnt_big;
	logic signed [CRD_W-1:0]   lo;
	logic [CRD_W-1:0]          mag;
	logic [CW-1:0]             tot;
	logic                      add_ok;

	logic                      pat_we;
	logic                      cur_we;
	logic [IW-1:0]             cur_wa;
	logic [CUW-1:0]            cur_wd;

	assign in_stall   = (state_q != S_IDLE);
	assign in_take    = in_valid && !in_stall;
	assign out_valid  = out_valid_q;
	assign coordinate = coordinate_q;
	assign status     = status_q;
	assign rd_addr    = cnt_q[IW-1:0];

	assign scan_val  = cur_rd_q[CUW-1:CW];
	assign scan_left = cur_rd_q[CW-1:0];
	assign pat_start = pat_rd_q[PW-1 -: CRD_W];
	assign pat_pitch = pat_rd_q[CW+CRD_W-1 -: CRD_W];
	assign pat_total = pat_rd_q[CW-1:0];

	always_comb begin
		nv  = scan_val;
		nl  = scan_left;
		hit = 1'b0;
		if (rew_q) begin
			nv = pat_start;
			nl = pat_total;
		end else if (scan_left != '0 && scan_val == hit_q) begin
			hit = 1'b1;
			nl  = scan_left - CW'(1);
			if (nl != '0) begin
				nv = scan_val + pat_pitch;
			end
		end
		take = v_s1 && (nl != '0) && (!acc_found_q || nv < acc_best_q);
	end

	assign cm1     = lines_q - LINES_W'(1);
	assign last    = origin_q + prod_s2;
	assign in_rng  = (&last[MW:CRD_W-1]) || !(|last[MW:CRD_W-1]);
	assign cnt32   = {{(CRD_W-LINES_W){1'b0}}, lines_q};
	assign cnt_big = (cnt32 >> COUNT_BITS) != '0;
	assign lo      = pitch_q[CRD_W-1] ? last[CRD_W-1:0] : origin_q;
	assign mag     = pitch_q[CRD_W-1] ? (CRD_W'(0) - pitch_q) : pitch_q;
	assign tot     = (mag == '0) ? CW'(1) : cnt32[CW-1:0];
	assign add_ok  = in_rng && !cnt_big;

	assign pat_we = (state_q == S_CHK) && add_ok;
	assign cur_we = pat_we || (v_s1 && (rew_q || hit));
	assign cur_wa = (state_q == S_CHK) ? used_q[IW-1:0] : addr_s1;
	assign cur_wd = (state_q == S_CHK) ? {lo, tot} : {nv, nl};

	always_ff @(posedge clk) begin
		if (pat_we) begin
			pat_mem[used_q[IW-1:0]] <= {lo, mag, tot};
		end
		pat_rd_q <= pat_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cur_we) begin
			cur_mem[cur_wa] <= cur_wd;
		end
		cur_rd_q <= cur_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			used_q        <= '0;
			cnt_q         <= '0;
			v_s1          <= 1'b0;
			addr_s1       <= '0;
			rew_q         <= 1'b0;
			hit_q         <= '0;
			acc_found_q   <= 1'b0;
			acc_best_q    <= '0;
			cache_found_q <= 1'b0;
			cache_best_q  <= '0;
			origin_q      <= '0;
			lines_q       <= '0;
			pitch_q       <= '0;
			prod_s2       <= '0;
			res_status_q  <= ST_OK;
			res_coord_q   <= '0;
			out_valid_q   <= 1'b0;
			status_q      <= ST_OK;
			coordinate_q  <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						res_coord_q <= '0;
						origin_q    <= origin;
						lines_q     <= lines;
						pitch_q     <= pitch;
						cnt_q       <= '0;
						v_s1        <= 1'b0;
						acc_found_q <= 1'b0;
						unique case (cmd_t'(command))
							CMD_CLEAR: begin
								used_q        <= '0;
								cache_found_q <= 1'b0;
								res_status_q  <= ST_OK;
								state_q       <= S_FIN;
							end
							CMD_ADD: begin
								if (lines[LINES_W-1] || lines == '0) begin
									res_status_q <= ST_OK;
									state_q      <= S_FIN;
								end else if (used_q == UW'(MAX_PATTERNS)) begin
									res_status_q <= ST_FULL;
									state_q      <= S_FIN;
								end else begin
									state_q <= S_MUL;
								end
							end
							CMD_NEXT: begin
								if (!cache_found_q) begin
									res_status_q <= ST_EXHAUSTED;
									state_q      <= S_FIN;
								end else begin
									hit_q   <= cache_best_q;
									rew_q   <= 1'b0;
									state_q <= S_SCAN;
								end
							end
							CMD_REWIND: begin
								rew_q   <= 1'b1;
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_MUL: begin
					prod_s2 <= cm1 * pitch_q;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (add_ok) begin
						res_status_q <= ST_OK;
						used_q       <= used_q + UW'(1);
						if (!cache_found_q || lo < cache_best_q) begin
							cache_best_q <= lo;
						end
						cache_found_q <= 1'b1;
					end else begin
						res_status_q <= ST_RANGE;
					end
					state_q <= S_FIN;
				end
				S_SCAN: begin
					v_s1    <= (cnt_q != used_q);
					addr_s1 <= cnt_q[IW-1:0];
					if (cnt_q != used_q) begin
						cnt_q <= cnt_q + UW'(1);
					end
					if (take) begin
						acc_found_q <= 1'b1;
						acc_best_q  <= nv;
					end
					if (cnt_q == used_q && !v_s1) begin
						cache_found_q <= acc_found_q;
						cache_best_q  <= acc_best_q;
						if (rew_q) begin
							res_status_q <= ST_OK;
							res_coord_q  <= '0;
						end else begin
							res_status_q <= ST_COORD;
							res_coord_q  <= hit_q;
						end
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						status_q     <= res_status_q;
						coordinate_q <= res_coord_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(MAX_PATTERNS))
		else $error("pattern count beyond table depth");

	a_scan_addr: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (UW'(addr_s1) < used_q))
		else $error("walk read beyond filled entries");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && command == CMD_CLEAR) |=> (used_q == '0 && !cache_found_q))
		else $error("clear left the table populated");

	a_coord_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_COORD) |-> (coordinate_q == '0))
		else $error("coordinate not zero without a coordinate status");

	a_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_we && state_q != S_CHK) |-> (state_q == S_SCAN && v_s1))
		else $error("cursor write outside a walk");

endmodule
